[src/t8cpu_pkg.sv]
`timescale 1ns / 1ps

package t8cpu_pkg;

	localparam int ADDR_W = 12;
	localparam int WORD_W = 16;
	localparam int REG_W = 8;
	localparam int REG_IDX_W = 4;

	localparam int DEF_MEM_WORDS = 64;
	localparam int DEF_STACK_DEPTH = 16;

	localparam logic [ADDR_W-1:0] PL_RESET = 12'hFFF;
	localparam logic [REG_IDX_W-1:0] CARRY_REG = 4'hF;

	localparam logic [2:0] FN_WRITE_MEM = 3'd0;
	localparam logic [2:0] FN_STEP = 3'd1;
	localparam logic [2:0] FN_START = 3'd2;
	localparam logic [2:0] FN_READ_MEM = 3'd3;
	localparam logic [2:0] FN_READ_REG = 3'd4;

	localparam logic [3:0] OP_NOP = 4'h0;
	localparam logic [3:0] OP_HALT = 4'h1;
	localparam logic [3:0] OP_RET = 4'h2;
	localparam logic [3:0] OP_JUMP = 4'h3;
	localparam logic [3:0] OP_CALL = 4'h4;
	localparam logic [3:0] OP_SET_DP = 4'h5;
	localparam logic [3:0] OP_LOAD_IMM = 4'h6;
	localparam logic [3:0] OP_ADD_IMM = 4'h7;
	localparam logic [3:0] OP_SUB_IMM = 4'h8;
	localparam logic [3:0] OP_REG = 4'h9;
	localparam logic [3:0] OP_SKIP = 4'hA;

	localparam logic [3:0] RS_STORE = 4'h0;
	localparam logic [3:0] RS_LOAD = 4'h1;
	localparam logic [3:0] RS_MOVE = 4'h2;
	localparam logic [3:0] RS_OR = 4'h3;
	localparam logic [3:0] RS_AND = 4'h4;
	localparam logic [3:0] RS_XOR = 4'h5;
	localparam logic [3:0] RS_ADD = 4'h6;
	localparam logic [3:0] RS_SUB = 4'h7;

	localparam logic [3:0] SK_EQ = 4'h0;
	localparam logic [3:0] SK_NE = 4'h1;
	localparam logic [3:0] SK_LT = 4'h2;
	localparam logic [3:0] SK_GT = 4'h3;

	typedef struct packed {
		logic [2:0] func;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wword;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pl;
		logic [ADDR_W-1:0] dp;
		logic running;
		logic fault;
	} state_t;

	typedef struct packed {
		logic we;
		logic [REG_IDX_W-1:0] idx;
		logic [REG_W-1:0] data;
		logic carry_we;
		logic [REG_W-1:0] carry_data;
	} rf_wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pl;
		logic [ADDR_W-1:0] dp;
		logic running;
		logic fault;
		logic executed;
		logic push;
		logic pop;
		logic [ADDR_W-1:0] push_data;
		logic mem_we;
		logic [ADDR_W-1:0] mem_addr;
		logic [WORD_W-1:0] mem_wdata;
		rf_wr_t rf;
		logic [WORD_W-1:0] rdata;
	} upd_t;

endpackage

[src/t8cpu_word_mem.sv]
`timescale 1ns / 1ps

module t8cpu_word_mem #(
	parameter int MEM_WORDS = t8cpu_pkg::DEF_MEM_WORDS
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [$clog2(MEM_WORDS)-1:0] rd_addr_a,
	input logic [$clog2(MEM_WORDS)-1:0] rd_addr_b,
	output logic [t8cpu_pkg::WORD_W-1:0] rd_data_a,
	output logic [t8cpu_pkg::WORD_W-1:0] rd_data_b,
	input logic we,
	input logic [$clog2(MEM_WORDS)-1:0] waddr,
	input logic [t8cpu_pkg::WORD_W-1:0] wdata,
	output logic busy
);
	import t8cpu_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

	logic [WORD_W-1:0] mem_q [0:MEM_WORDS-1];
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;
	logic [WORD_W-1:0] byp_data_q;
	logic byp_a_q;
	logic byp_b_q;
	logic clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign wr_en = clr_busy_q | we;
	assign wr_addr = clr_busy_q ? clr_idx_q : waddr;
	assign wr_data = clr_busy_q ? '0 : wdata;
	assign busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
		end
	end

	// A read in the same cycle as a write to the same word returns the new word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
			byp_a_q <= we && (waddr == rd_addr_a);
			byp_b_q <= we && (waddr == rd_addr_b);
			byp_data_q <= wdata;
		end
	end

	assign rd_data_a = byp_a_q ? byp_data_q : rd_a_q;
	assign rd_data_b = byp_b_q ? byp_data_q : rd_b_q;

endmodule

[src/t8cpu_reg_file.sv]
`timescale 1ns / 1ps

module t8cpu_reg_file (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [t8cpu_pkg::REG_IDX_W-1:0] ra_idx,
	input logic [t8cpu_pkg::REG_IDX_W-1:0] rb_idx,
	output logic [t8cpu_pkg::REG_W-1:0] ra_data,
	output logic [t8cpu_pkg::REG_W-1:0] rb_data,
	input t8cpu_pkg::rf_wr_t wr
);
	import t8cpu_pkg::*;

	// Registers 0 to 14 live in the array; register 15 is a flop so that a
	// carry and a result can both be written by one instruction.
	localparam int RAM_REGS = 15;

	logic [REG_W-1:0] rf_q [0:RAM_REGS-1];
	logic [RAM_REGS-1:0] valid_q;
	logic [REG_W-1:0] r15_q;
	logic [REG_W-1:0] ra_q;
	logic [REG_W-1:0] rb_q;

	logic ram_we;

	assign ram_we = wr.we && (wr.idx != CARRY_REG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			r15_q <= '0;
		end else begin
			if (ram_we) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (wr.we && (wr.idx == CARRY_REG)) begin
				r15_q <= wr.data;
			end else if (wr.carry_we) begin
				r15_q <= wr.carry_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			rf_q[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			if (ra_idx == CARRY_REG) begin
				ra_q <= r15_q;
			end else begin
				ra_q <= valid_q[ra_idx] ? rf_q[ra_idx] : '0;
			end
			if (rb_idx == CARRY_REG) begin
				rb_q <= r15_q;
			end else begin
				rb_q <= valid_q[rb_idx] ? rf_q[rb_idx] : '0;
			end
		end
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

[src/t8cpu_exec.sv]
`timescale 1ns / 1ps

module t8cpu_exec #(
	parameter int MEM_WORDS = t8cpu_pkg::DEF_MEM_WORDS
) (
	input t8cpu_pkg::item_t item,
	input logic [t8cpu_pkg::WORD_W-1:0] iword,
	input logic [t8cpu_pkg::WORD_W-1:0] dword,
	input logic [t8cpu_pkg::REG_W-1:0] ra,
	input logic [t8cpu_pkg::REG_W-1:0] rb,
	input t8cpu_pkg::state_t st,
	input logic stk_empty,
	input logic stk_full,
	input logic [t8cpu_pkg::ADDR_W-1:0] stk_top,
	output t8cpu_pkg::upd_t upd
);
	import t8cpu_pkg::*;

	localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_WORDS);

	logic [ADDR_W-1:0] pl_inc;
	logic [ADDR_W-1:0] oper;
	logic [3:0] opc;
	logic [3:0] hi;
	logic [REG_W-1:0] imm;
	logic fetch_ok;
	logic dp_ok;
	logic host_ok;
	logic [REG_W:0] sum9;
	logic carry;
	logic borrow;
	logic take;
	logic [REG_W-1:0] base;

	always_comb begin
		pl_inc = st.pl + 12'd1;
		opc = iword[15:12];
		oper = iword[11:0];
		hi = iword[11:8];
		imm = iword[7:0];
		fetch_ok = {1'b0, pl_inc} < MEM_LIMIT;
		dp_ok = {1'b0, st.dp} < MEM_LIMIT;
		host_ok = {1'b0, item.addr} < MEM_LIMIT;
		sum9 = {1'b0, ra} + {1'b0, imm};
		carry = sum9[REG_W];
		borrow = imm > ra;
		base = ra;

		case (hi)
			SK_EQ: take = (ra == rb);
			SK_NE: take = (ra != rb);
			SK_LT: take = (ra < rb);
			SK_GT: take = (ra > rb);
			default: take = 1'b0;
		endcase

		upd.pl = st.pl;
		upd.dp = st.dp;
		upd.running = st.running;
		upd.fault = st.fault;
		upd.executed = 1'b0;
		upd.push = 1'b0;
		upd.pop = 1'b0;
		upd.push_data = pl_inc;
		upd.mem_we = 1'b0;
		upd.mem_addr = item.addr;
		upd.mem_wdata = item.wword;
		upd.rf.we = 1'b0;
		upd.rf.idx = hi;
		upd.rf.data = imm;
		upd.rf.carry_we = 1'b0;
		upd.rf.carry_data = '0;
		upd.rdata = '0;

		case (item.func)
			FN_WRITE_MEM: begin
				upd.mem_we = host_ok;
			end
			FN_STEP: begin
				if (st.running) begin
					upd.pl = pl_inc;
					if (!fetch_ok) begin
						upd.running = 1'b0;
					end else begin
						upd.executed = 1'b1;
						case (opc)
							OP_HALT: begin
								upd.running = 1'b0;
							end
							OP_RET: begin
								if (stk_empty) begin
									upd.fault = 1'b1;
									upd.running = 1'b0;
								end else begin
									upd.pop = 1'b1;
									upd.pl = stk_top;
								end
							end
							OP_JUMP: begin
								upd.pl = oper - 12'd1;
							end
							OP_CALL: begin
								if (stk_full) begin
									upd.fault = 1'b1;
									upd.running = 1'b0;
								end else begin
									upd.push = 1'b1;
									upd.pl = oper - 12'd1;
								end
							end
							OP_SET_DP: begin
								upd.dp = oper;
							end
							OP_LOAD_IMM: begin
								upd.rf.we = 1'b1;
							end
							OP_ADD_IMM: begin
								// With register 15 as target the sum builds on the fresh carry.
								base = (hi == CARRY_REG) ? {7'd0, carry} : ra;
								upd.rf.we = 1'b1;
								upd.rf.data = base + imm;
								upd.rf.carry_we = 1'b1;
								upd.rf.carry_data = {7'd0, carry};
							end
							OP_SUB_IMM: begin
								base = (hi == CARRY_REG) ? {7'd0, borrow} : ra;
								upd.rf.we = 1'b1;
								upd.rf.data = base - imm;
								upd.rf.carry_we = 1'b1;
								upd.rf.carry_data = {7'd0, borrow};
							end
							OP_REG: begin
								upd.rf.idx = iword[7:4];
								case (hi)
									RS_STORE: begin
										upd.mem_we = dp_ok;
										upd.mem_addr = st.dp;
										upd.mem_wdata = {8'd0, ra};
									end
									RS_LOAD: begin
										upd.rf.we = 1'b1;
										upd.rf.data = dp_ok ? dword[7:0] : '0;
									end
									RS_MOVE: begin
										upd.rf.we = 1'b1;
										upd.rf.data = rb;
									end
									RS_OR: begin
										upd.rf.we = 1'b1;
										upd.rf.data = ra | rb;
									end
									RS_AND: begin
										upd.rf.we = 1'b1;
										upd.rf.data = ra & rb;
									end
									RS_XOR: begin
										upd.rf.we = 1'b1;
										upd.rf.data = ra ^ rb;
									end
									RS_ADD: begin
										upd.rf.we = 1'b1;
										upd.rf.data = ra + rb;
									end
									RS_SUB: begin
										upd.rf.we = 1'b1;
										upd.rf.data = ra - rb;
									end
									default: begin
									end
								endcase
							end
							OP_SKIP: begin
								if (take) begin
									upd.pl = pl_inc + 12'd1;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			FN_START: begin
				upd.running = 1'b1;
			end
			FN_READ_MEM: begin
				upd.rdata = host_ok ? iword : '0;
			end
			FN_READ_REG: begin
				upd.rdata = (item.addr[11:4] == 8'd0) ? {8'd0, ra} : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

[src/tiny_8bit_register_cpu.sv]
`timescale 1ns / 1ps

// Channel | Handshake             | Payload
// cmd     | cmd_valid, cmd_ready  | func, target_address, write_word
// rsp     | rsp_valid, rsp_ready  | read_data, program_location, is_running,
//         |                       | did_execute, stack_fault
//
// A transfer on cmd is taken only while the fetch stage is empty and the execute
// stage is empty or emptying; the result reaches the output register after the word
// memory read, the register file read and execute. The fetch of the next step uses
// the location being written by the current one, so a new transfer waits for it.
// After reset the word memory is cleared with cmd_ready low.
// A stalled rsp holds the result and the execute stage, and cmd_ready drops
// until the output register frees.

module tiny_8bit_register_cpu #(
	parameter int MEM_WORDS = t8cpu_pkg::DEF_MEM_WORDS,
	parameter int STACK_DEPTH = t8cpu_pkg::DEF_STACK_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input logic [2:0] func,
	input logic [t8cpu_pkg::ADDR_W-1:0] target_address,
	input logic [t8cpu_pkg::WORD_W-1:0] write_word,
	output logic rsp_valid,
	input logic rsp_ready,
	output logic [t8cpu_pkg::WORD_W-1:0] read_data,
	output logic [t8cpu_pkg::ADDR_W-1:0] program_location,
	output logic is_running,
	output logic did_execute,
	output logic stack_fault
);
	import t8cpu_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic cmd_fire;
	logic s1_adv;
	logic s2_go;
	logic mem_busy;

	logic valid_s1;
	logic valid_s2;
	item_t item_s1;
	item_t item_s2;
	logic [WORD_W-1:0] iword_s2;
	logic [WORD_W-1:0] dword_s2;

	logic [ADDR_W-1:0] pl_q;
	logic [ADDR_W-1:0] dp_q;
	logic running_q;
	logic fault_q;
	logic [CW-1:0] cnt_q;
	logic [ADDR_W-1:0] stack_q [0:STACK_DEPTH-1];

	logic rsp_valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic [ADDR_W-1:0] pl_out_q;
	logic running_out_q;
	logic executed_q;
	logic fault_out_q;

	logic [ADDR_W-1:0] fwd_pl;
	logic [ADDR_W-1:0] fwd_dp;
	logic [ADDR_W-1:0] fetch_addr;
	logic [WORD_W-1:0] iword_s1;
	logic [WORD_W-1:0] dword_s1;
	logic [3:0] opc_s1;
	logic [REG_IDX_W-1:0] ra_idx;
	logic [REG_IDX_W-1:0] rb_idx;
	logic [REG_W-1:0] ra_data;
	logic [REG_W-1:0] rb_data;
	logic [CW-1:0] cnt_m1;
	logic stk_empty;
	logic stk_full;
	logic [ADDR_W-1:0] stk_top;
	state_t st;
	upd_t upd;
	rf_wr_t rf_wr;
	item_t cmd_item;

	assign s2_go = valid_s2 && (!rsp_valid_q || rsp_ready);
	assign s1_adv = valid_s1 && (!valid_s2 || s2_go);
	assign cmd_ready = !mem_busy && !valid_s1 && (!valid_s2 || s2_go);
	assign cmd_fire = cmd_valid && cmd_ready;

	assign cmd_item.func = func;
	assign cmd_item.addr = target_address;
	assign cmd_item.wword = write_word;

	// The item leaving execute in this cycle supplies the location and pointer
	// that the incoming item fetches with.
	assign fwd_pl = valid_s2 ? upd.pl : pl_q;
	assign fwd_dp = valid_s2 ? upd.dp : dp_q;
	assign fetch_addr = (func == FN_READ_MEM) ? target_address : fwd_pl + 12'd1;

	t8cpu_word_mem #(
		.MEM_WORDS(MEM_WORDS)
	) u_word_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(cmd_fire),
		.rd_addr_a(fetch_addr[AW-1:0]),
		.rd_addr_b(fwd_dp[AW-1:0]),
		.rd_data_a(iword_s1),
		.rd_data_b(dword_s1),
		.we(s2_go && upd.mem_we),
		.waddr(upd.mem_addr[AW-1:0]),
		.wdata(upd.mem_wdata),
		.busy(mem_busy)
	);

	assign opc_s1 = iword_s1[15:12];

	always_comb begin
		if (item_s1.func == FN_READ_REG) begin
			ra_idx = item_s1.addr[REG_IDX_W-1:0];
		end else if (opc_s1 inside {OP_ADD_IMM, OP_SUB_IMM}) begin
			ra_idx = iword_s1[11:8];
		end else begin
			ra_idx = iword_s1[7:4];
		end
		rb_idx = iword_s1[3:0];
	end

	always_comb begin
		rf_wr = upd.rf;
		rf_wr.we = upd.rf.we && s2_go;
		rf_wr.carry_we = upd.rf.carry_we && s2_go;
	end

	t8cpu_reg_file u_reg_file (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(s1_adv),
		.ra_idx(ra_idx),
		.rb_idx(rb_idx),
		.ra_data(ra_data),
		.rb_data(rb_data),
		.wr(rf_wr)
	);

	assign cnt_m1 = cnt_q - CW'(1);
	assign stk_empty = (cnt_q == '0);
	assign stk_full = (cnt_q >= CW'(STACK_DEPTH));
	assign stk_top = stack_q[cnt_m1[SIW-1:0]];

	always_comb begin
		st.pl = pl_q;
		st.dp = dp_q;
		st.running = running_q;
		st.fault = fault_q;
	end

	t8cpu_exec #(
		.MEM_WORDS(MEM_WORDS)
	) u_exec (
		.item(item_s2),
		.iword(iword_s2),
		.dword(dword_s2),
		.ra(ra_data),
		.rb(rb_data),
		.st(st),
		.stk_empty(stk_empty),
		.stk_full(stk_full),
		.stk_top(stk_top),
		.upd(upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pl_q <= PL_RESET;
			dp_q <= '0;
			running_q <= 1'b0;
			fault_q <= 1'b0;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				pl_q <= upd.pl;
				dp_q <= upd.dp;
				running_q <= upd.running;
				fault_q <= upd.fault;
				if (upd.push) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (upd.pop) begin
					cnt_q <= cnt_m1;
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			item_s1 <= cmd_item;
		end
		if (s1_adv) begin
			item_s2 <= item_s1;
			iword_s2 <= iword_s1;
			dword_s2 <= dword_s1;
		end
		if (s2_go && upd.push) begin
			stack_q[cnt_q[SIW-1:0]] <= upd.push_data;
		end
		if (s2_go) begin
			rdata_q <= upd.rdata;
			pl_out_q <= upd.pl;
			running_out_q <= upd.running;
			executed_q <= upd.executed;
			fault_out_q <= upd.fault;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = rdata_q;
	assign program_location = pl_out_q;
	assign is_running = running_out_q;
	assign did_execute = executed_q;
	assign stack_fault = fault_out_q;

`ifndef SYNTHESIS
	a_one_item_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("Fetch and execute stages both hold an item.");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("Return stack count exceeds its depth.");

	a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !cmd_fire)
		else $error("Command transfer during the memory clearing pass.");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("Stack fault flag was cleared.");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import t8cpu_pkg::*;

	localparam int MEM_WORDS = DEF_MEM_WORDS;
	localparam int STACK_DEPTH = DEF_STACK_DEPTH;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS = 17;
	localparam logic [2:0] FN_UNUSED = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] rdata;
		logic [ADDR_W-1:0] pl;
		logic running;
		logic executed;
		logic fault;
	} response_t;

	typedef struct packed {
		logic [2:0] func_code;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
		logic [7:0] reps;
		logic fixed;
		response_t known;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [2:0] func = '0;
	logic [ADDR_W-1:0] target_address = '0;
	logic [WORD_W-1:0] write_word = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [WORD_W-1:0] read_data;
	logic [ADDR_W-1:0] program_location;
	logic is_running;
	logic did_execute;
	logic stack_fault;

	logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
	logic [REG_W-1:0] shadow_regs [16];
	logic [ADDR_W-1:0] shadow_stack [STACK_DEPTH];
	int shadow_depth;
	logic [ADDR_W-1:0] shadow_pl;
	logic [ADDR_W-1:0] shadow_dp;
	logic shadow_running;
	logic shadow_fault;

	response_t pending_responses [$];
	row_t dir_rows [DIR_ROWS];
	int mismatches = 0;
	int burst_left = 0;
	int items_sent = 0;
	int cycle_count = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int pattern_age = 0;

	tiny_8bit_register_cpu #(
		.MEM_WORDS(MEM_WORDS),
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.func(func),
		.target_address(target_address),
		.write_word(write_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.read_data(read_data),
		.program_location(program_location),
		.is_running(is_running),
		.did_execute(did_execute),
		.stack_fault(stack_fault)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic response_t apply_command(input logic [2:0] fc, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] word);
		response_t r;
		logic [WORD_W-1:0] instr;
		logic [3:0] opc;
		logic [3:0] hi;
		logic [3:0] ra;
		logic [3:0] rb;
		logic [ADDR_W-1:0] opnd;
		logic [REG_W-1:0] imm;
		logic [REG_W-1:0] old;
		logic [REG_W-1:0] x;
		logic [REG_W-1:0] y;
		logic take;
		r = '0;
		case (fc)
			FN_WRITE_MEM: begin
				if (addr < MEM_WORDS)
					shadow_mem[addr] = word;
			end
			FN_STEP: begin
				if (shadow_running) begin
					shadow_pl = shadow_pl + 12'd1;
					if (shadow_pl >= MEM_WORDS) begin
						shadow_running = 1'b0;
					end else begin
						r.executed = 1'b1;
						instr = shadow_mem[shadow_pl];
						opc = instr[15:12];
						opnd = instr[11:0];
						hi = opnd[11:8];
						ra = opnd[7:4];
						rb = opnd[3:0];
						imm = opnd[7:0];
						x = shadow_regs[ra];
						y = shadow_regs[rb];
						take = 1'b0;
						case (opc)
							OP_HALT: shadow_running = 1'b0;
							OP_RET: begin
								if (shadow_depth == 0) begin
									shadow_fault = 1'b1;
									shadow_running = 1'b0;
								end else begin
									shadow_depth--;
									shadow_pl = shadow_stack[shadow_depth];
								end
							end
							OP_JUMP: shadow_pl = opnd - 12'd1;
							OP_CALL: begin
								if (shadow_depth >= STACK_DEPTH) begin
									shadow_fault = 1'b1;
									shadow_running = 1'b0;
								end else begin
									shadow_stack[shadow_depth] = shadow_pl;
									shadow_depth++;
									shadow_pl = opnd - 12'd1;
								end
							end
							OP_SET_DP: shadow_dp = opnd;
							OP_LOAD_IMM: shadow_regs[hi] = imm;
							OP_ADD_IMM: begin
								old = shadow_regs[hi];
								shadow_regs[CARRY_REG] =
									(({1'b0, old} + {1'b0, imm}) > 9'd255) ? 8'd1 : 8'd0;
								shadow_regs[hi] = shadow_regs[hi] + imm;
							end
							OP_SUB_IMM: begin
								old = shadow_regs[hi];
								shadow_regs[CARRY_REG] = (imm > old) ? 8'd1 : 8'd0;
								shadow_regs[hi] = shadow_regs[hi] - imm;
							end
							OP_REG: begin
								case (hi)
									RS_STORE: begin
										if (shadow_dp < MEM_WORDS)
											shadow_mem[shadow_dp] = {8'h00, x};
									end
									RS_LOAD: begin
										shadow_regs[ra] = (shadow_dp < MEM_WORDS) ?
											shadow_mem[shadow_dp][7:0] : 8'h00;
									end
									RS_MOVE: shadow_regs[ra] = y;
									RS_OR: shadow_regs[ra] = x | y;
									RS_AND: shadow_regs[ra] = x & y;
									RS_XOR: shadow_regs[ra] = x ^ y;
									RS_ADD: shadow_regs[ra] = x + y;
									RS_SUB: shadow_regs[ra] = x - y;
									default: ;
								endcase
							end
							OP_SKIP: begin
								case (hi)
									SK_EQ: take = (x == y);
									SK_NE: take = (x != y);
									SK_LT: take = (x < y);
									SK_GT: take = (x > y);
									default: take = 1'b0;
								endcase
								if (take)
									shadow_pl = shadow_pl + 12'd1;
							end
							default: ;
						endcase
					end
				end
			end
			FN_START: shadow_running = 1'b1;
			FN_READ_MEM: begin
				if (addr < MEM_WORDS)
					r.rdata = shadow_mem[addr];
			end
			FN_READ_REG: begin
				if (addr < 16)
					r.rdata = {8'h00, shadow_regs[addr[3:0]]};
			end
			default: ;
		endcase
		r.pl = shadow_pl;
		r.running = shadow_running;
		r.fault = shadow_fault;
		return r;
	endfunction

	task automatic send_cmd(input logic [2:0] fc, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] word, input logic use_known = 1'b0, input response_t known = '0);
		response_t model_rsp;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		func <= fc;
		target_address <= addr;
		write_word <= word;
		do
			@(posedge clk);
		while (!cmd_ready);
		model_rsp = apply_command(fc, addr, word);
		pending_responses.push_back(use_known ? known : model_rsp);
		items_sent++;
	endtask

	task automatic load_program(input logic whole);
		int count;
		int slot;
		int pick;
		logic [3:0] opc;
		logic [ADDR_W-1:0] opnd;
		count = whole ? MEM_WORDS - 2 : $urandom_range(4, 12);
		for (int i = 0; i < count; i++) begin
			slot = whole ? i : $urandom_range(0, MEM_WORDS - 3);
			pick = $urandom_range(0, 99);
			opnd = 12'($urandom());
			if (pick < 3)
				opc = OP_HALT;
			else if (pick < 9)
				opc = OP_RET;
			else if (pick < 15)
				opc = OP_JUMP;
			else if (pick < 21)
				opc = OP_CALL;
			else if (pick < 27)
				opc = OP_SET_DP;
			else if (pick < 41)
				opc = OP_LOAD_IMM;
			else if (pick < 50)
				opc = OP_ADD_IMM;
			else if (pick < 59)
				opc = OP_SUB_IMM;
			else if (pick < 79)
				opc = OP_REG;
			else if (pick < 92)
				opc = OP_SKIP;
			else if (pick < 95)
				opc = OP_NOP;
			else
				opc = 4'(OP_SKIP + $urandom_range(1, 5));
			// Most targets stay below the two closing jumps; a PL_RESET target runs off memory.
			case (opc)
				OP_JUMP, OP_CALL: begin
					case ($urandom_range(0, 15))
						0: opnd = PL_RESET;
						1: opnd = '0;
						default: opnd = 12'($urandom_range(0, MEM_WORDS - 3));
					endcase
				end
				OP_SET_DP: begin
					if ($urandom_range(0, 7) != 0)
						opnd = 12'($urandom_range(0, MEM_WORDS - 3));
					else
						opnd = 12'($urandom_range(MEM_WORDS, 4095));
				end
				OP_REG: begin
					if ($urandom_range(0, 7) != 0)
						opnd[11:8] = 4'($urandom_range(RS_STORE, RS_SUB));
				end
				OP_SKIP: begin
					if ($urandom_range(0, 7) != 0)
						opnd[11:8] = 4'($urandom_range(SK_EQ, SK_GT));
				end
				default: ;
			endcase
			send_cmd(FN_WRITE_MEM, 12'(slot), {opc, opnd});
		end
		send_cmd(FN_WRITE_MEM, 12'(MEM_WORDS - 2), {OP_JUMP, 12'h000});
		send_cmd(FN_WRITE_MEM, 12'(MEM_WORDS - 1), {OP_JUMP, 12'h000});
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		mismatches++;
		$display("Mismatch on %s at cycle %0d: got %h, expected %h.", what, cycle_count,
			got, want);
	endtask

	always @(posedge clk) begin
		response_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("unexpected transfer", read_data, '0);
			end else begin
				want = pending_responses.pop_front();
				if (read_data !== want.rdata)
					report_mismatch("read_data", read_data, want.rdata);
				if (program_location !== want.pl)
					report_mismatch("program_location", program_location, want.pl);
				if (is_running !== want.running)
					report_mismatch("is_running", is_running, want.running);
				if (did_execute !== want.executed)
					report_mismatch("did_execute", did_execute, want.executed);
				if (stack_fault !== want.fault)
					report_mismatch("stack_fault", stack_fault, want.fault);
			end
		end
	end

	always @(posedge clk) begin
		if (pattern_age == 0) begin
			pattern_age <= $urandom_range(16, 96);
			if ($urandom_range(0, 3) == 0)
				ready_pattern <= 16'hFFFF;
			else
				ready_pattern <= 16'($urandom()) | 16'h0101;
			rsp_ready <= 1'b1;
		end else begin
			pattern_age <= pattern_age - 1;
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
			rsp_ready <= ready_pattern[0];
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int steps;
		int pick;
		int random_start;
		for (int i = 0; i < MEM_WORDS; i++)
			shadow_mem[i] = '0;
		for (int i = 0; i < 16; i++)
			shadow_regs[i] = '0;
		for (int i = 0; i < STACK_DEPTH; i++)
			shadow_stack[i] = '0;
		shadow_depth = 0;
		shadow_pl = PL_RESET;
		shadow_dp = '0;
		shadow_running = 1'b0;
		shadow_fault = 1'b0;

		dir_rows = '{
			'{FN_READ_REG, 12'hFFF, 16'h0000, 8'd1, 1'b1, '{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b0}},
			'{FN_READ_MEM, 12'hFFF, 16'h0000, 8'd1, 1'b1, '{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b0}},
			'{FN_WRITE_MEM, 12'hFFF, 16'hFFFF, 8'd1, 1'b1, '{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b0}},
			'{FN_STEP, 12'hFFF, 16'hFFFF, 8'd1, 1'b1, '{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b0}},
			'{FN_UNUSED, 12'hFFF, 16'hFFFF, 8'd1, 1'b1, '{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b0}},
			'{FN_WRITE_MEM, 12'h000, {OP_RET, 12'h000}, 8'd1, 1'b1,
				'{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b0}},
			'{FN_START, 12'h000, 16'h0000, 8'd1, 1'b1, '{16'h0000, PL_RESET, 1'b1, 1'b0, 1'b0}},
			'{FN_STEP, 12'h000, 16'h0000, 8'd1, 1'b1, '{16'h0000, 12'h000, 1'b0, 1'b1, 1'b1}},
			'{FN_WRITE_MEM, 12'h001, {OP_CALL, 12'h001}, 8'd1, 1'b1,
				'{16'h0000, 12'h000, 1'b0, 1'b0, 1'b1}},
			'{FN_START, 12'h000, 16'h0000, 8'd1, 1'b1, '{16'h0000, 12'h000, 1'b1, 1'b0, 1'b1}},
			'{FN_STEP, 12'h000, 16'h0000, 8'(STACK_DEPTH + 1), 1'b0, '0},
			'{FN_WRITE_MEM, 12'h002, {OP_JUMP, 12'hFFF}, 8'd1, 1'b0, '0},
			'{FN_WRITE_MEM, 12'(MEM_WORDS - 1), 16'hFFFF, 8'd1, 1'b0, '0},
			'{FN_START, 12'h000, 16'h0000, 8'd1, 1'b0, '0},
			'{FN_STEP, 12'h000, 16'h0000, 8'd2, 1'b0, '0},
			'{FN_READ_MEM, 12'(MEM_WORDS - 1), 16'h0000, 8'd1, 1'b1,
				'{16'hFFFF, PL_RESET, 1'b0, 1'b0, 1'b1}},
			'{FN_READ_REG, {8'h00, CARRY_REG}, 16'h0000, 8'd1, 1'b1,
				'{16'h0000, PL_RESET, 1'b0, 1'b0, 1'b1}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			repeat (dir_rows[i].reps)
				send_cmd(dir_rows[i].func_code, dir_rows[i].addr, dir_rows[i].word,
					dir_rows[i].fixed, dir_rows[i].known);
		end

		random_start = items_sent;
		load_program(1'b1);
		while (items_sent - random_start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 4))
					send_cmd(3'($urandom_range(0, 7)), 12'($urandom()), 16'($urandom()));
			end else if (pick < 3) begin
				load_program(1'b0);
			end else begin
				if (!shadow_running)
					send_cmd(FN_START, 12'($urandom()), 16'($urandom()));
				steps = $urandom_range(4, 24);
				repeat (steps) begin
					case ($urandom_range(0, 19))
						0, 1: send_cmd(FN_READ_REG, 12'($urandom_range(0, 15)), 16'($urandom()));
						2: send_cmd(FN_READ_MEM, 12'($urandom_range(0, MEM_WORDS - 1)), 16'($urandom()));
						default: send_cmd(FN_STEP, 12'($urandom()), 16'($urandom()));
					endcase
				end
			end
		end

		cmd_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
src/t8cpu_pkg.sv
src/t8cpu_word_mem.sv
src/t8cpu_reg_file.sv
src/t8cpu_exec.sv
src/tiny_8bit_register_cpu.sv
dv/tb_top.sv
